// File: sv/pdfr_pkg.sv
package pdfr_pkg;

	// Default structural settings.
	localparam int TIMER_BITS_DEF   = 16;
	localparam int SYNC_REPEATS_DEF = 2;
	localparam int BYTE_Q_DEPTH_DEF = 2;
	localparam int RES_Q_DEPTH_DEF  = 2;

	// Field widths.
	localparam int TIME_W = 16;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CIDX_W-1:0] REG_BIT_THRESHOLD = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SYNC_PATTERN  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MAX_FRAME_LEN = 2'd2;

	// Register reset values.
	localparam logic [15:0] BIT_THRESHOLD_RST = 16'd900;
	localparam logic [7:0]  SYNC_PATTERN_RST  = 8'hAA;
	localparam logic [7:0]  MAX_FRAME_LEN_RST = 8'd32;

	// Result kinds.
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_SUM_OK   = 2'd1;
	localparam logic [1:0] KIND_SUM_BAD  = 2'd2;
	localparam logic [1:0] KIND_TOO_LONG = 2'd3;

	// One result beat.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [7:0] position;
		logic [7:0] length;
		logic [7:0] sum;
	} result_t;

endpackage

// File: sv/pdfr_fifo.sv
// Small first-in first-out queue in flip-flops. DEPTH must be a power of two.
module pdfr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: sv/pdfr_front.sv
// Line sampler: finds edges, times pulse gaps and assembles bytes MSB first.
module pdfr_front #(
	parameter int TIMER_BITS = pdfr_pkg::TIMER_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        line_level,
	input  logic [pdfr_pkg::TIME_W-1:0] time_us,
	input  logic [15:0]                 bit_threshold_us,
	output logic                        byte_push,
	output logic [7:0]                  byte_data
);

	// Compare width wide enough for both the gap and the threshold.
	localparam int CW = (TIMER_BITS > pdfr_pkg::TIME_W) ? TIMER_BITS : pdfr_pkg::TIME_W;

	logic                  last_level_q;
	logic [TIMER_BITS-1:0] rise_q;
	logic [2:0]            bits_q;
	logic [7:0]            shift_q;
	logic [CW-1:0]         now_w;
	logic [TIMER_BITS-1:0] now_t;
	logic [TIMER_BITS-1:0] gap;
	logic                  bit_val;
	logic                  rise_edge;
	logic                  fall_edge;

	// Timestamp reduced to the timer width, gap modulo the timer range.
	always_comb begin
		now_w     = CW'(time_us);
		now_t     = now_w[TIMER_BITS-1:0];
		gap       = now_t - rise_q;
		bit_val   = (CW'(gap) >= CW'(bit_threshold_us));
		rise_edge = !last_level_q && line_level;
		fall_edge = last_level_q && !line_level;
		byte_data = {shift_q[6:0], bit_val};
		byte_push = accept && fall_edge && (bits_q == 3'd7);
	end

	// Edge and bit state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			rise_q       <= '0;
			bits_q       <= '0;
			shift_q      <= '0;
		end else if (accept) begin
			last_level_q <= line_level;
			if (rise_edge) begin
				rise_q <= now_t;
			end else if (fall_edge) begin
				if (bits_q == 3'd7) begin
					bits_q  <= '0;
					shift_q <= '0;
				end else begin
					bits_q  <= bits_q + 3'd1;
					shift_q <= byte_data;
				end
			end
		end
	end

endmodule

// File: sv/pdfr_back.sv
// Frame parser: sync hunt, length check, payload and checksum.
module pdfr_back #(
	parameter int SYNC_REPEATS = pdfr_pkg::SYNC_REPEATS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic [7:0]        byte_in,
	output logic              byte_pop,
	input  logic              res_full,
	input  logic [7:0]        sync_pattern,
	input  logic [7:0]        max_frame_len,
	output logic              res_push,
	output pdfr_pkg::result_t res
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	localparam logic [1:0] SYNC_LAST = 2'(SYNC_REPEATS);

	logic [1:0] phase_q;
	logic [1:0] seen_q;
	logic [7:0] len_q;
	logic [7:0] count_q;
	logic [7:0] sum_q;
	logic [1:0] seen_n;
	logic [7:0] sum_n;
	logic       has_res;

	assign byte_pop = byte_valid && !res_full;
	assign res_push = byte_pop && has_res;
	assign seen_n   = seen_q + 2'd1;
	assign sum_n    = sum_q + byte_in;

	// Result for the byte at the head of the queue.
	always_comb begin
		has_res      = 1'b0;
		res.kind     = pdfr_pkg::KIND_DATA;
		res.value    = byte_in;
		res.position = '0;
		res.length   = len_q;
		res.sum      = sum_q;
		unique case (phase_q)
			PH_LEN: begin
				if (byte_in > max_frame_len) begin
					has_res    = 1'b1;
					res.kind   = pdfr_pkg::KIND_TOO_LONG;
					res.length = byte_in;
					res.sum    = '0;
				end
			end
			PH_BODY: begin
				has_res = 1'b1;
				if (count_q < len_q) begin
					res.position = count_q;
					res.sum      = sum_n;
				end else if (sum_q == byte_in) begin
					res.kind = pdfr_pkg::KIND_SUM_OK;
				end else begin
					res.kind = pdfr_pkg::KIND_SUM_BAD;
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	// Frame state advances once per byte taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			seen_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (byte_pop) begin
			unique case (phase_q)
				PH_LEN: begin
					len_q <= byte_in;
					if (byte_in > max_frame_len) begin
						phase_q <= PH_HUNT;
					end else begin
						phase_q <= PH_BODY;
					end
				end
				PH_BODY: begin
					if (count_q < len_q) begin
						sum_q   <= sum_n;
						count_q <= count_q + 8'd1;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				default: begin
					if (byte_in == sync_pattern) begin
						if (seen_n >= SYNC_LAST) begin
							phase_q <= PH_LEN;
							seen_q  <= '0;
							len_q   <= '0;
							count_q <= '0;
							sum_q   <= '0;
						end else begin
							seen_q <= seen_n;
						end
					end else begin
						seen_q <= '0;
					end
				end
			endcase
		end
	end

endmodule

// File: sv/pulse_distance_frame_receiver_top.sv
// Channel   Direction  Handshake               Beat contents
// input     in         push / full             line_level, time_us
// result    out        empty / pop             result_kind, byte_value, byte_position,
//                                              frame_length, computed_sum
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample is taken every cycle in which push is high and full is low; a completed
// byte is registered in the byte queue, then its result in the result queue.
// The byte queue between sampler and frame parser sets the input stall: full is
// high only while that queue is full, which needs the result side to back up.
// Reset clears all control state and loads the register defaults; cfg_ready is
// always high.
module pulse_distance_frame_receiver_top #(
	parameter int TIMER_BITS   = pdfr_pkg::TIMER_BITS_DEF,
	parameter int SYNC_REPEATS = pdfr_pkg::SYNC_REPEATS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        line_level,
	input  logic [pdfr_pkg::TIME_W-1:0] time_us,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  result_kind,
	output logic [7:0]                  byte_value,
	output logic [7:0]                  byte_position,
	output logic [7:0]                  frame_length,
	output logic [7:0]                  computed_sum,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pdfr_pkg::CIDX_W-1:0] cfg_index,
	input  logic [pdfr_pkg::CFG_W-1:0]  cfg_data
);

	localparam int RES_W = $bits(pdfr_pkg::result_t);

	logic [15:0]       bit_threshold_q;
	logic [7:0]        sync_pattern_q;
	logic [7:0]        max_frame_len_q;
	logic              accept;
	logic              byte_push;
	logic [7:0]        byte_data;
	logic              byte_full;
	logic              byte_empty;
	logic [7:0]        byte_head;
	logic              byte_pop;
	logic              res_full;
	logic              res_push;
	pdfr_pkg::result_t res_in;
	pdfr_pkg::result_t res_out;
	logic [RES_W-1:0]  res_bits;

	assign cfg_ready = 1'b1;
	assign full      = byte_full;
	assign accept    = push && !byte_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_threshold_q <= pdfr_pkg::BIT_THRESHOLD_RST;
			sync_pattern_q  <= pdfr_pkg::SYNC_PATTERN_RST;
			max_frame_len_q <= pdfr_pkg::MAX_FRAME_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pdfr_pkg::REG_BIT_THRESHOLD: bit_threshold_q <= cfg_data[15:0];
				pdfr_pkg::REG_SYNC_PATTERN:  sync_pattern_q  <= cfg_data[7:0];
				pdfr_pkg::REG_MAX_FRAME_LEN: max_frame_len_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Sampler and byte assembler.
	pdfr_front #(
		.TIMER_BITS(TIMER_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.line_level      (line_level),
		.time_us         (time_us),
		.bit_threshold_us(bit_threshold_q),
		.byte_push       (byte_push),
		.byte_data       (byte_data)
	);

	// Queue of finished bytes.
	pdfr_fifo #(
		.WIDTH(8),
		.DEPTH(pdfr_pkg::BYTE_Q_DEPTH_DEF)
	) u_byte_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (byte_push),
		.wr_data(byte_data),
		.rd_en  (byte_pop),
		.rd_data(byte_head),
		.full   (byte_full),
		.empty  (byte_empty)
	);

	// Frame parser.
	pdfr_back #(
		.SYNC_REPEATS(SYNC_REPEATS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (!byte_empty),
		.byte_in      (byte_head),
		.byte_pop     (byte_pop),
		.res_full     (res_full),
		.sync_pattern (sync_pattern_q),
		.max_frame_len(max_frame_len_q),
		.res_push     (res_push),
		.res          (res_in)
	);

	// Result queue in front of the output ports.
	pdfr_fifo #(
		.WIDTH(RES_W),
		.DEPTH(pdfr_pkg::RES_Q_DEPTH_DEF)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.rd_en  (pop),
		.rd_data(res_bits),
		.full   (res_full),
		.empty  (empty)
	);

	assign res_out       = pdfr_pkg::result_t'(res_bits);
	assign result_kind   = res_out.kind;
	assign byte_value    = res_out.value;
	assign byte_position = res_out.position;
	assign frame_length  = res_out.length;
	assign computed_sum  = res_out.sum;

endmodule
